FILE: rtl/clcd_pkg.sv
// Shared types and constants for the character LCD bus engine.
// No dependencies; used by clcd_seq and char_lcd_bus_interface_core.
`default_nettype none

package clcd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned RES_W   = 24;

    localparam logic [BYTE_W-1:0] BUSY_FLAG  = 8'h80;
    localparam logic [BYTE_W-1:0] ONE_TICK   = 8'h01;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] PULSE_TICKS_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] BUSY_TIMEOUT_RST = 8'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOUR_BIT  = 2'd0,
        CFG_READ_BACK = 2'd1,
        CFG_PULSE     = 2'd2,
        CFG_TIMEOUT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_NIBBLE = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_WR_HI = 4'd1,
        PH_WR_LO = 4'd2,
        PH_WAIT  = 4'd3,
        PH_RD_HI = 4'd4,
        PH_RD_LO = 4'd5
    } t_phase;

    typedef struct packed {
        logic              four_bit_mode;
        logic              read_back_enable;
        logic [BYTE_W-1:0] pulse_ticks;
        logic [BYTE_W-1:0] busy_timeout;
    } t_cfg;

    typedef struct packed {
        logic              lcd_e;
        logic              lcd_rs;
        logic              lcd_rw;
        logic [BYTE_W-1:0] bus_out;
        logic              bus_drive;
        logic              ready_res;
        logic              done_res;
        logic              timed_out;
        logic              rejected;
        logic [BYTE_W-1:0] status_byte;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/char_lcd_bus_interface_core.sv
// Top level of the character LCD bus engine: config registers, stream ports, result register.
// Depends on clcd_pkg and clcd_seq.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser opcode, tdata data/sample
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata line levels and status
//  cfg      | in  | i_cfg_we (no wait)             | i_cfg_addr, i_cfg_wdata
//
// One word per cycle: each accepted input word is one display tick and yields one result
// word in the output register on the following cycle.
// The input side stays ready while the result register is empty or being taken this cycle.
// When the output stalls the result holds and the sequencer does not advance.
// Reset clears the sequencer to idle and loads the config defaults; no clearing pass.
`default_nettype none

module char_lcd_bus_interface_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // config write port
    input  wire                             i_cfg_we,
    input  wire [clcd_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire [clcd_pkg::BYTE_W-1:0]      i_cfg_wdata,
    // input stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [2*clcd_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] data_byte, [15:8] bus_sample
    input  wire [clcd_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] opcode
    // result stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [clcd_pkg::RES_W-1:0]      m_axis_tdata   // [0] lcd_e, [1] lcd_rs, [2] lcd_rw,
                                                           // [10:3] bus_out, [11] bus_drive,
                                                           // [12] ready_res, [13] done_res,
                                                           // [14] timed_out, [15] rejected,
                                                           // [23:16] status_byte
);

    clcd_pkg::t_cfg    r_cfg;
    clcd_pkg::t_result step_res;
    logic              step;
    logic              r_out_valid;
    logic [clcd_pkg::RES_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.four_bit_mode    <= 1'b0;
            r_cfg.read_back_enable <= 1'b1;
            r_cfg.pulse_ticks      <= clcd_pkg::PULSE_TICKS_RST;
            r_cfg.busy_timeout     <= clcd_pkg::BUSY_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (clcd_pkg::t_cfg_idx'(i_cfg_addr))
                clcd_pkg::CFG_FOUR_BIT:  r_cfg.four_bit_mode    <= i_cfg_wdata[0];
                clcd_pkg::CFG_READ_BACK: r_cfg.read_back_enable <= i_cfg_wdata[0];
                clcd_pkg::CFG_PULSE:     r_cfg.pulse_ticks      <= i_cfg_wdata;
                clcd_pkg::CFG_TIMEOUT:   r_cfg.busy_timeout     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    clcd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_op     (clcd_pkg::t_opcode'(s_axis_tuser)),
        .i_data   (s_axis_tdata[clcd_pkg::BYTE_W-1:0]),
        .i_sample (s_axis_tdata[2*clcd_pkg::BYTE_W-1:clcd_pkg::BYTE_W]),
        .i_cfg    (r_cfg),
        .o_res    (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {step_res.status_byte, step_res.rejected, step_res.timed_out,
                           step_res.done_res, step_res.ready_res, step_res.bus_drive,
                           step_res.bus_out, step_res.lcd_rw, step_res.lcd_rs,
                           step_res.lcd_e};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/clcd_seq.sv
// Tick sequencer of the character LCD bus engine: phase, counters and held bytes.
// Advances one tick per accepted word. Depends on clcd_pkg.
`default_nettype none

module clcd_seq (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_step,
    input  wire clcd_pkg::t_opcode     i_op,
    input  wire [clcd_pkg::BYTE_W-1:0] i_data,
    input  wire [clcd_pkg::BYTE_W-1:0] i_sample,
    input  wire clcd_pkg::t_cfg        i_cfg,
    output clcd_pkg::t_result          o_res
);

    clcd_pkg::t_phase            r_phase, n_phase;
    logic [clcd_pkg::BYTE_W-1:0] r_tick, n_tick;
    logic [clcd_pkg::BYTE_W-1:0] r_polls, n_polls;
    logic                        r_second, n_second;
    logic                        r_rs, n_rs;
    logic [clcd_pkg::BYTE_W-1:0] r_held, n_held;
    logic [clcd_pkg::BYTE_W-1:0] r_read, n_read;
    logic                        r_raw, n_raw;

    logic                        last_tick;
    logic [clcd_pkg::BYTE_W-1:0] wr_value;

    assign last_tick = (r_tick == clcd_pkg::ONE_TICK);

    always_comb begin
        if (r_raw || (i_cfg.four_bit_mode && r_second)) begin
            wr_value = {r_held[3:0], 4'h0};
        end else if (i_cfg.four_bit_mode) begin
            wr_value = {r_held[7:4], 4'h0};
        end else begin
            wr_value = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= clcd_pkg::PH_IDLE;
            r_tick   <= '0;
            r_polls  <= '0;
            r_second <= 1'b0;
            r_rs     <= 1'b0;
            r_held   <= '0;
            r_read   <= '0;
            r_raw    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_polls  <= n_polls;
            r_second <= n_second;
            r_rs     <= n_rs;
            r_held   <= n_held;
            r_read   <= n_read;
            r_raw    <= n_raw;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_tick   = last_tick ? r_tick : r_tick - clcd_pkg::ONE_TICK;
        n_polls  = r_polls;
        n_second = r_second;
        n_rs     = r_rs;
        n_held   = r_held;
        n_read   = r_read;
        n_raw    = r_raw;
        o_res    = '0;

        case (r_phase)
            clcd_pkg::PH_WR_HI, clcd_pkg::PH_WR_LO: begin
                o_res.lcd_e     = (r_phase == clcd_pkg::PH_WR_HI);
                o_res.lcd_rs    = r_rs;
                o_res.bus_out   = wr_value;
                o_res.bus_drive = 1'b1;
                if (last_tick) begin
                    if (r_phase == clcd_pkg::PH_WR_HI) begin
                        n_phase = clcd_pkg::PH_WR_LO;
                        n_tick  = i_cfg.pulse_ticks;
                    end else if (!r_raw && i_cfg.four_bit_mode && !r_second) begin
                        n_second = 1'b1;
                        n_phase  = clcd_pkg::PH_WR_HI;
                        n_tick   = i_cfg.pulse_ticks;
                    end else if (r_raw) begin
                        o_res.done_res = 1'b1;
                        n_phase        = clcd_pkg::PH_IDLE;
                    end else if (i_cfg.read_back_enable) begin
                        n_polls = i_cfg.busy_timeout - clcd_pkg::ONE_TICK;
                        if (n_polls == '0) begin
                            // budget of one: no read at all
                            o_res.done_res  = 1'b1;
                            o_res.timed_out = 1'b1;
                            n_phase         = clcd_pkg::PH_IDLE;
                        end else begin
                            n_second = 1'b0;
                            n_phase  = clcd_pkg::PH_RD_HI;
                            n_tick   = i_cfg.pulse_ticks;
                        end
                    end else begin
                        n_phase = clcd_pkg::PH_WAIT;
                        n_tick  = i_cfg.busy_timeout;
                    end
                end
            end
            clcd_pkg::PH_WAIT: begin
                o_res.lcd_rs    = r_rs;
                o_res.bus_out   = wr_value;
                o_res.bus_drive = 1'b1;
                if (last_tick) begin
                    o_res.done_res = 1'b1;
                    n_phase        = clcd_pkg::PH_IDLE;
                end
            end
            clcd_pkg::PH_RD_HI: begin
                o_res.lcd_e  = 1'b1;
                o_res.lcd_rw = 1'b1;
                if (last_tick) begin
                    // sample on the last E-high tick
                    if (!i_cfg.four_bit_mode) begin
                        n_read = i_sample;
                    end else if (!r_second) begin
                        n_read = {i_sample[7:4], 4'h0};
                    end else begin
                        n_read = {r_read[7:4], i_sample[7:4]};
                    end
                    n_phase = clcd_pkg::PH_RD_LO;
                    n_tick  = i_cfg.pulse_ticks;
                end
            end
            clcd_pkg::PH_RD_LO: begin
                o_res.lcd_rw = 1'b1;
                if (last_tick) begin
                    if (i_cfg.four_bit_mode && !r_second) begin
                        n_second = 1'b1;
                        n_phase  = clcd_pkg::PH_RD_HI;
                        n_tick   = i_cfg.pulse_ticks;
                    end else begin
                        n_polls = r_polls - clcd_pkg::ONE_TICK;
                        if ((r_read & clcd_pkg::BUSY_FLAG) == '0) begin
                            o_res.done_res = 1'b1;
                            n_phase        = clcd_pkg::PH_IDLE;
                        end else if (n_polls == '0) begin
                            o_res.done_res  = 1'b1;
                            o_res.timed_out = 1'b1;
                            n_phase         = clcd_pkg::PH_IDLE;
                        end else begin
                            n_second = 1'b0;
                            n_phase  = clcd_pkg::PH_RD_HI;
                            n_tick   = i_cfg.pulse_ticks;
                        end
                    end
                end
            end
            clcd_pkg::PH_IDLE: begin
                o_res.ready_res = 1'b1;
                if (i_op != clcd_pkg::OP_TICK) begin
                    n_rs     = (i_op == clcd_pkg::OP_DATA);
                    n_raw    = (i_op == clcd_pkg::OP_NIBBLE);
                    n_held   = i_data;
                    n_second = 1'b0;
                    n_phase  = clcd_pkg::PH_WR_HI;
                    n_tick   = i_cfg.pulse_ticks;
                end
            end
            default: begin
                n_phase = clcd_pkg::PH_IDLE;
            end
        endcase

        o_res.rejected    = !o_res.ready_res && (i_op != clcd_pkg::OP_TICK);
        o_res.status_byte = n_read;
    end

`ifndef ASSERT_OFF
    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_tick) && $stable(r_read))
        else $error("sequencer state moved without an accepted word");

    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == clcd_pkg::PH_IDLE && i_op != clcd_pkg::OP_TICK)
        |=> r_phase == clcd_pkg::PH_WR_HI)
        else $error("accepted send did not start a write strobe");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> r_phase == clcd_pkg::PH_IDLE)
        else $error("transfer finished but engine not idle");

    a_timeout_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.timed_out |-> o_res.done_res && r_phase != clcd_pkg::PH_IDLE)
        else $error("timeout flagged outside a transfer end");
`endif

endmodule

`default_nettype wire
